// ===== design/lpct_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear-probe connection table package
// Shared types, codes and sizes for the connection table and its memory.
// ----------------------------------------------------------------------------
`default_nettype none

package lpct_pkg;

  localparam int SLOT_BITS_DEFAULT = 10;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== design/lpct_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpct_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/linear_probe_connection_table_top.sv =====
// ----------------------------------------------------------------------------
// Linear-probe connection table
// Open-addressing table of connection entries keyed by descriptor, with
// add, remove and find requests resolved by linear probing in one RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  func, conn_id, ip_addr, ip_port
//   response  rsp_valid / rsp_stall  status, slot, found_addr, found_port
//
// A transaction is accepted and then probes one slot at a time, from 1 up to
// 2^SLOT_BITS probes; the single RAM read port sets this one-slot pace.
// After reset a clearing pass over all 2^SLOT_BITS slots zeroes the table, and no
// request is accepted until it ends. A response waiting under rsp_stall does
// not block the next request; the probe then holds at its current slot.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_connection_table_top #(
  parameter int SLOT_BITS = lpct_pkg::SLOT_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [lpct_pkg::FUNC_W-1:0]   func,
  input  wire logic [lpct_pkg::KEY_W-1:0]    conn_id,
  input  wire logic [lpct_pkg::ADDR_W-1:0]   ip_addr,
  input  wire logic [lpct_pkg::PORT_W-1:0]   ip_port,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic      [lpct_pkg::STATUS_W-1:0] status,
  output logic      [lpct_pkg::SLOT_W-1:0]   slot,
  output logic      [lpct_pkg::ADDR_W-1:0]   found_addr,
  output logic      [lpct_pkg::PORT_W-1:0]   found_port
);

  localparam int DEPTH  = 1 << SLOT_BITS;
  localparam int WIDE_W = (SLOT_BITS > lpct_pkg::SLOT_W) ? SLOT_BITS : lpct_pkg::SLOT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_t;

  state_t                        state;
  logic [SLOT_BITS-1:0]          pos;
  logic [SLOT_BITS-1:0]          count;
  logic [lpct_pkg::FUNC_W-1:0]   req_func;
  logic [lpct_pkg::KEY_W-1:0]    req_key;
  logic [lpct_pkg::ADDR_W-1:0]   req_addr;
  logic [lpct_pkg::PORT_W-1:0]   req_port;

  logic                          wr_en;
  logic [SLOT_BITS-1:0]          wr_addr;
  lpct_pkg::entry_t              wr_entry;
  logic [SLOT_BITS-1:0]          rd_addr;
  logic [lpct_pkg::ENTRY_W-1:0]  rd_data;
  lpct_pkg::entry_t              rd_entry;

  logic                          out_free;
  logic                          last;
  logic                          found;
  logic                          known_func;
  logic                          decide;
  logic                          advance;
  logic [SLOT_BITS-1:0]          pos_inc;
  logic [WIDE_W-1:0]             pos_wide;

  lpct_ram #(
    .WIDTH (lpct_pkg::ENTRY_W),
    .DEPTH (DEPTH),
    .ADDR_W(SLOT_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_entry  = lpct_pkg::entry_t'(rd_data);
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign last      = (count == {SLOT_BITS{1'b1}});
  assign pos_inc   = pos + SLOT_BITS'(1);
  assign pos_wide  = WIDE_W'(pos);

  always_comb begin
    found      = 1'b0;
    known_func = 1'b1;
    case (req_func)
      lpct_pkg::FUNC_ADD: begin
        found = !rd_entry.valid;
      end
      lpct_pkg::FUNC_REMOVE, lpct_pkg::FUNC_FIND: begin
        found = rd_entry.valid && (rd_entry.key == req_key);
      end
      default: begin
        known_func = 1'b0;
      end
    endcase
  end

  assign decide  = (state == ST_PROBE) && out_free && (found || last || !known_func);
  assign advance = (state == ST_PROBE) && out_free && !found && !last && known_func;

  always_comb begin
    unique case (state)
      ST_IDLE:  rd_addr = conn_id[SLOT_BITS-1:0];
      ST_PROBE: rd_addr = advance ? pos_inc : pos;
      default:  rd_addr = pos;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_entry = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (decide && found && known_func) begin
      wr_en = (req_func == lpct_pkg::FUNC_ADD) || (req_func == lpct_pkg::FUNC_REMOVE);
      if (req_func == lpct_pkg::FUNC_ADD) begin
        wr_entry.valid = 1'b1;
        wr_entry.key   = req_key;
        wr_entry.addr  = req_addr;
        wr_entry.port  = req_port;
      end else begin
        wr_entry       = rd_entry;
        wr_entry.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pos       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (decide) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          pos <= pos_inc;
          if (pos == {SLOT_BITS{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            pos      <= conn_id[SLOT_BITS-1:0];
            count    <= '0;
            req_func <= func;
            req_key  <= conn_id;
            req_addr <= ip_addr;
            req_port <= ip_port;
            state    <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (advance) begin
            pos   <= pos_inc;
            count <= count + SLOT_BITS'(1);
          end
          if (decide) begin
            state <= ST_IDLE;
            if (found && known_func) begin
              status <= lpct_pkg::STATUS_OK;
              slot   <= pos_wide[lpct_pkg::SLOT_W-1:0];
              if (req_func == lpct_pkg::FUNC_ADD) begin
                found_addr <= req_addr;
                found_port <= req_port;
              end else begin
                found_addr <= rd_entry.addr;
                found_port <= rd_entry.port;
              end
            end else begin
              status     <= (known_func && req_func == lpct_pkg::FUNC_ADD) ?
                            lpct_pkg::STATUS_FULL : lpct_pkg::STATUS_MISS;
              slot       <= '0;
              found_addr <= '0;
              found_port <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
